FILE: rtl/rmst_pkg.sv
package rmst_pkg;

  localparam int LEAVES_DEFAULT = 1024;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 10;
  localparam int END_W   = 11;
  localparam int COUNT_W = 11;
  localparam int VALUE_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
  localparam logic signed [VALUE_W-1:0] NODE_MIN = 32'sh8000_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_RANGE = 2'd2,
    CMD_ALL   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_UP_READ,
    ST_UP_WRITE,
    ST_Q_RUN,
    ST_Q_FIN,
    ST_DONE
  } state_t;

  function automatic logic signed [VALUE_W-1:0] max_of(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: rtl/rmst_req_if.sv
interface rmst_req_if;
  import rmst_pkg::*;

  logic                      valid;
  logic                      ready;
  cmd_t                      cmd;
  logic [POS_W-1:0]          position;
  logic [END_W-1:0]          range_end;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, cmd, position, range_end, value, input ready);
  modport sink (input valid, cmd, position, range_end, value, output ready);
endinterface

FILE: rtl/rmst_rsp_if.sv
interface rmst_rsp_if;
  import rmst_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] result_value;
  logic                      index_error;

  modport source (output valid, result_value, index_error, input ready);
  modport sink (input valid, result_value, index_error, output ready);
endinterface

FILE: rtl/rmst_cfg_if.sv
interface rmst_cfg_if;
  import rmst_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] element_count;

  modport source (output valid, element_count, input ready);
  modport sink (input valid, element_count, output ready);
endinterface

FILE: rtl/range_max_segment_tree.sv
// Channel | Dir | Payload                                   | Accepted when
// --------+-----+-------------------------------------------+---------------------
// cfg     | in  | element_count[10:0]                       | cfg.valid & cfg.ready
// req     | in  | cmd[1:0] position[9:0] range_end[10:0]    | req.valid & req.ready
//         |     | value[31:0] (signed)                      |
// rsp     | out | result_value[31:0] (signed) index_error   | rsp.valid & rsp.ready
//
// One request at a time. The node store is one memory (one write port, two
// registered read ports). A point write walks leaf to root; at each level it
// reads the sibling, then writes the parent. A range or full-maximum query
// reads two nodes per level. Reset and every element_count write start a
// clearing pass that writes the most negative value into all 2*LEAVES nodes,
// one per cycle; no request is accepted until it ends. The result sits in an
// output register, so a stalled rsp only holds the sequencer at its final step.
module range_max_segment_tree #(
  parameter int LEAVES = rmst_pkg::LEAVES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  rmst_cfg_if.sink   cfg,
  rmst_req_if.sink   req,
  rmst_rsp_if.source rsp
);
  import rmst_pkg::*;

  // node store: leaf p at LEAVES+p, inner node k holds max of 2k and 2k+1
  localparam int DEPTH = 2 * LEAVES;
  localparam int AW    = $clog2(DEPTH);
  // working width for positions, bounds and compares
  localparam int WW    = ((AW > COUNT_W) ? AW : COUNT_W) + 1;

  state_t state, state_next;

  logic [COUNT_W-1:0] element_count;
  logic [AW-1:0]      clr_addr, clr_addr_next;

  logic [VALUE_W-1:0] tree_nodes [0:DEPTH-1];
  logic               mem_we;
  logic [AW-1:0]      mem_wa, ra, rb;
  logic signed [VALUE_W-1:0] mem_wd, rdata_a, rdata_b;

  // write walk: current node and the new value coming up from below
  logic [AW-1:0]             node, node_next;
  logic signed [VALUE_W-1:0] carry, carry_next;

  // query window and partial maxima
  logic [WW-1:0]             lo, lo_next, hi, hi_next;
  logic signed [VALUE_W-1:0] left_max, right_max;
  logic                      pend_l, pend_l_next, pend_r, pend_r_next;
  logic                      q_start;

  logic signed [VALUE_W-1:0] res_val, res_val_next;
  logic                      res_err, res_err_next;
  logic                      load_rsp;

  logic          cfg_fire, req_fire;
  logic [WW-1:0] cnt, pos_w, end_w, leaf_w;

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid;
  assign req.ready = (state == ST_IDLE) && !cfg.valid;
  assign req_fire  = req.valid && req.ready;

  // active count is min(element_count, LEAVES)
  assign cnt    = (WW'(element_count) > WW'(LEAVES)) ? WW'(LEAVES) : WW'(element_count);
  assign pos_w  = WW'(req.position);
  assign end_w  = WW'(req.range_end);
  assign leaf_w = pos_w + WW'(LEAVES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    node_next     = node;
    carry_next    = carry;
    lo_next       = lo;
    hi_next       = hi;
    pend_l_next   = 1'b0;
    pend_r_next   = 1'b0;
    q_start       = 1'b0;
    res_val_next  = res_val;
    res_err_next  = res_err;
    load_rsp      = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = node;
    mem_wd        = carry;
    ra            = node;
    rb            = node;

    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
        mem_wd = NODE_MIN;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end

      ST_IDLE: begin
        if (req_fire) begin
          res_val_next = NODE_MIN;
          res_err_next = 1'b0;
          case (req.cmd)
            CMD_WRITE: begin
              if (pos_w >= cnt) begin
                res_err_next = 1'b1;
                state_next   = ST_DONE;
              end else begin
                mem_we       = 1'b1;
                mem_wa       = leaf_w[AW-1:0];
                mem_wd       = req.value;
                node_next    = leaf_w[AW-1:0];
                carry_next   = req.value;
                res_val_next = req.value;
                state_next   = ST_UP_READ;
              end
            end
            CMD_READ: begin
              if (pos_w >= cnt) begin
                res_err_next = 1'b1;
                state_next   = ST_DONE;
              end else begin
                ra         = leaf_w[AW-1:0];
                state_next = ST_RD_WAIT;
              end
            end
            CMD_RANGE: begin
              if (pos_w > cnt || end_w > cnt) begin
                res_err_next = 1'b1;
                state_next   = ST_DONE;
              end else if (pos_w >= end_w) begin
                state_next = ST_DONE;
              end else begin
                lo_next    = leaf_w;
                hi_next    = end_w + WW'(LEAVES);
                q_start    = 1'b1;
                state_next = ST_Q_RUN;
              end
            end
            CMD_ALL: begin
              lo_next    = WW'(LEAVES);
              hi_next    = WW'(DEPTH);
              q_start    = 1'b1;
              state_next = ST_Q_RUN;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end

      ST_RD_WAIT: begin
        res_val_next = rdata_a;
        state_next   = ST_DONE;
      end

      // fetch the sibling of the node just written
      ST_UP_READ: begin
        if (node == AW'(1)) begin
          state_next = ST_DONE;
        end else begin
          ra         = node ^ AW'(1);
          state_next = ST_UP_WRITE;
        end
      end

      ST_UP_WRITE: begin
        mem_we     = 1'b1;
        mem_wa     = node >> 1;
        mem_wd     = max_of(carry, rdata_a);
        carry_next = max_of(carry, rdata_a);
        node_next  = node >> 1;
        state_next = ST_UP_READ;
      end

      // one tree level per cycle; the read data is folded in on the next cycle
      ST_Q_RUN: begin
        if (lo < hi) begin
          pend_l_next = lo[0];
          pend_r_next = hi[0];
          ra          = lo[AW-1:0];
          rb          = AW'(hi - WW'(1));
          lo_next     = (lo + WW'(lo[0])) >> 1;
          hi_next     = hi >> 1;
        end else begin
          state_next = ST_Q_FIN;
        end
      end

      ST_Q_FIN: begin
        res_val_next = max_of(left_max, right_max);
        state_next   = ST_DONE;
      end

      ST_DONE: begin
        if (!rsp.valid || rsp.ready) begin
          load_rsp   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // a count write empties the tree
    if (cfg_fire) begin
      state_next    = ST_CLEAR;
      clr_addr_next = '0;
    end
  end

  // node memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tree_nodes[mem_wa] <= mem_wd;
    end
    rdata_a <= tree_nodes[ra];
    rdata_b <= tree_nodes[rb];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= COUNT_RESET;
      clr_addr      <= '0;
      pend_l        <= 1'b0;
      pend_r        <= 1'b0;
      rsp.valid     <= 1'b0;
    end else begin
      if (cfg_fire) begin
        element_count <= cfg.element_count;
      end
      clr_addr <= clr_addr_next;
      pend_l   <= pend_l_next;
      pend_r   <= pend_r_next;
      if (load_rsp) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    node    <= node_next;
    carry   <= carry_next;
    lo      <= lo_next;
    hi      <= hi_next;
    res_val <= res_val_next;
    res_err <= res_err_next;
    if (q_start) begin
      left_max  <= NODE_MIN;
      right_max <= NODE_MIN;
    end else begin
      if (pend_l) begin
        left_max <= max_of(left_max, rdata_a);
      end
      if (pend_r) begin
        right_max <= max_of(rdata_b, right_max);
      end
    end
    if (load_rsp) begin
      rsp.result_value <= res_val;
      rsp.index_error  <= res_err;
    end
  end

endmodule
